### rtl/core/ttb_pkg.sv
// Shared types and constants of the translation table builder.
`timescale 1ns / 1ps
`default_nettype none
package ttb_pkg;

   localparam logic [1:0] CMD_SETUP = 2'd0;
   localparam logic [1:0] CMD_AREA  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOSLOT = 2'd1;
   localparam logic [1:0] ST_NOROOT = 2'd2;
   localparam logic [1:0] ST_BADPTR = 2'd3;

   localparam logic CSR_TABLE_BASE  = 1'b0;
   localparam logic CSR_TABLE_LIMIT = 1'b1;

   localparam logic [31:0] DESC_TABLE   = 32'h0000_0003;
   localparam logic [63:0] DESC_BLOCK   = 64'h1;
   localparam logic [63:0] DESC_PAGE    = 64'h3;
   localparam logic [63:0] SPLIT_MARK   = 64'h2;
   localparam logic [31:0] PTR_MASK     = 32'hffff_fffc;
   localparam logic [31:0] PAGE_SIZE    = 32'h0000_1000;
   localparam logic [31:0] BLOCK_SIZE   = 32'h0020_0000;
   localparam logic [9:0]  ENTRY_COUNT  = 10'd512;
   localparam logic [8:0]  ENTRY_LAST   = 9'd511;
   localparam logic [1:0]  LINK_LAST    = 2'd3;
   localparam logic [4:0]  SLOTS_SAT    = 5'd31;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] virt_start;
      logic [31:0] phys_start;
      logic [31:0] phys_end;
      logic [63:0] attr;
      logic        last_area;
      logic [3:0]  read_slot;
      logic [8:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] root_address;
      logic [63:0] read_data;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_ALIGN, OP_ALLOC, OP_BUMP, OP_DEC_ROOT, OP_LINK,
      OP_SET_ROOT, OP_NOROOT, OP_DEC_CUR, OP_RD_ROOT, OP_DEC_L2, OP_BLOCK,
      OP_NEXT_IDX, OP_RD_L2E, OP_LATCH_E, OP_SET_E, OP_DEC_SPLIT, OP_SPLIT,
      OP_DEC_L3, OP_PAGE, OP_PG_RET, OP_AREA_END, OP_RD_DATA, OP_LATCH_DATA,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   load;
      logic   tail;
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic       fault;
      logic [1:0] command;
      logic       root_open;
      logic       e_zero;
      logic       e_block;
      logic       page_more;
      logic       block_more;
      logic       fin;
      logic       pg_need;
      logic       tail_need;
      logic       split_last;
      logic       link_last;
      logic       clear_last;
      logic       out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/core/translation_table_builder_core.sv
// Top level of the translation table builder.
//
//  channel  | handshake              | payload
//  request  | req_valid / req_ready  | req_data  (req_type)
//  response | rsp_valid / rsp_ready  | rsp_data  (rsp_type)
//  config   | csr_we                 | csr_index, csr_wdata
//
// One request at a time. An add-area writes one descriptor per cycle (blocks,
// pages and 512 per split), with table lookups in between; the single table
// store port sets this. After reset a clearing pass zeroes all NUM_SLOTS*512
// entries of the store; no request is taken until it ends. A stalled response
// holds; the next request waits until its own response can be loaded.
`timescale 1ns / 1ps
`default_nettype none
module translation_table_builder_core import ttb_pkg::*; #(
   parameter int NUM_SLOTS  = 16,
   parameter int SLOT_SHIFT = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   ctl_cmd_type cmd;
   dp_stat_type stat;

   ttb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttb_dp #(.NUM_SLOTS(NUM_SLOTS), .SLOT_SHIFT(SLOT_SHIFT)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );
endmodule
`default_nettype wire

### rtl/core/ttb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ttb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

### rtl/core/ttb_ctrl.sv
// Sequencer state machine of the translation table builder.
`timescale 1ns / 1ps
`default_nettype none
module ttb_ctrl import ttb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output ctl_cmd_type      cmd
);
   typedef enum logic [27:0] {
      S_CLEAR      = 28'h000_0001,
      S_IDLE       = 28'h000_0002,
      S_DISPATCH   = 28'h000_0004,
      S_ALIGN      = 28'h000_0008,
      S_ALLOC_ROOT = 28'h000_0010,
      S_BUMP       = 28'h000_0020,
      S_DEC_ROOT   = 28'h000_0040,
      S_ALLOC_LINK = 28'h000_0080,
      S_LINK       = 28'h000_0100,
      S_SET_ROOT   = 28'h000_0200,
      S_DEC_CUR    = 28'h000_0400,
      S_LOOP       = 28'h000_0800,
      S_DEC_L2     = 28'h000_1000,
      S_PG_CHK     = 28'h000_2000,
      S_BLOCK      = 28'h000_4000,
      S_RD_E       = 28'h000_8000,
      S_LATCH_E    = 28'h001_0000,
      S_E_CHK      = 28'h002_0000,
      S_ALLOC_E    = 28'h004_0000,
      S_SET_E      = 28'h008_0000,
      S_DEC_SPLIT  = 28'h010_0000,
      S_SPLIT      = 28'h020_0000,
      S_DEC_L3     = 28'h040_0000,
      S_PAGE       = 28'h080_0000,
      S_AREA_END   = 28'h100_0000,
      S_RD         = 28'h200_0000,
      S_RD_DATA    = 28'h400_0000,
      S_FINISH     = 28'h800_0000
   } state_type;

   state_type state_ff, state_in;
   logic      tail_ff, tail_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      tail_in  = tail_ff;
      cmd.load = 1'b0;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.command)
               CMD_SETUP: state_in = S_ALIGN;
               CMD_AREA: begin
                  if (stat.root_open) begin
                     state_in = S_DEC_CUR;
                  end else begin
                     cmd.op   = OP_NOROOT;
                     state_in = S_FINISH;
                  end
               end
               CMD_READ: state_in = S_RD;
               default:  state_in = S_FINISH;
            endcase
         end
         S_ALIGN: begin
            cmd.op   = OP_ALIGN;
            state_in = S_ALLOC_ROOT;
         end
         S_ALLOC_ROOT: begin
            cmd.op   = OP_ALLOC;
            state_in = stat.fault ? S_FINISH : S_BUMP;
         end
         S_BUMP: begin
            cmd.op   = OP_BUMP;
            state_in = S_DEC_ROOT;
         end
         S_DEC_ROOT: begin
            cmd.op   = OP_DEC_ROOT;
            state_in = stat.fault ? S_FINISH : S_ALLOC_LINK;
         end
         S_ALLOC_LINK: begin
            cmd.op   = OP_ALLOC;
            state_in = stat.fault ? S_FINISH : S_LINK;
         end
         S_LINK: begin
            cmd.op   = OP_LINK;
            state_in = stat.link_last ? S_SET_ROOT : S_ALLOC_LINK;
         end
         S_SET_ROOT: begin
            cmd.op   = OP_SET_ROOT;
            state_in = S_FINISH;
         end
         S_DEC_CUR: begin
            cmd.op   = OP_DEC_CUR;
            state_in = stat.fault ? S_AREA_END : S_LOOP;
         end
         S_LOOP: begin
            cmd.op   = OP_RD_ROOT;
            state_in = S_DEC_L2;
         end
         S_DEC_L2: begin
            cmd.op   = OP_DEC_L2;
            state_in = stat.fault ? S_AREA_END : S_PG_CHK;
         end
         S_PG_CHK: begin
            tail_in  = 1'b0;
            state_in = stat.pg_need ? S_RD_E : S_BLOCK;
         end
         S_BLOCK: begin
            if (stat.block_more) begin
               cmd.op = OP_BLOCK;
            end else if (!stat.fin) begin
               cmd.op   = OP_NEXT_IDX;
               state_in = S_LOOP;
            end else if (stat.tail_need) begin
               tail_in  = 1'b1;
               state_in = S_RD_E;
            end else begin
               state_in = S_AREA_END;
            end
         end
         S_RD_E: begin
            cmd.op   = OP_RD_L2E;
            state_in = S_LATCH_E;
         end
         S_LATCH_E: begin
            cmd.op   = OP_LATCH_E;
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            state_in = (stat.e_zero || stat.e_block) ? S_ALLOC_E : S_DEC_L3;
         end
         S_ALLOC_E: begin
            cmd.op   = OP_ALLOC;
            state_in = stat.fault ? S_AREA_END : S_SET_E;
         end
         S_SET_E: begin
            cmd.op   = OP_SET_E;
            state_in = stat.e_block ? S_DEC_SPLIT : S_DEC_L3;
         end
         S_DEC_SPLIT: begin
            cmd.op   = OP_DEC_SPLIT;
            state_in = stat.fault ? S_AREA_END : S_SPLIT;
         end
         S_SPLIT: begin
            cmd.op = OP_SPLIT;
            if (stat.split_last) state_in = S_DEC_L3;
         end
         S_DEC_L3: begin
            cmd.op   = OP_DEC_L3;
            state_in = stat.fault ? S_AREA_END : S_PAGE;
         end
         S_PAGE: begin
            if (stat.page_more) begin
               cmd.op = OP_PAGE;
            end else if (tail_ff) begin
               state_in = S_AREA_END;
            end else begin
               cmd.op   = OP_PG_RET;
               state_in = S_BLOCK;
            end
         end
         S_AREA_END: begin
            cmd.op   = OP_AREA_END;
            state_in = S_FINISH;
         end
         S_RD: begin
            cmd.op   = OP_RD_DATA;
            state_in = stat.fault ? S_FINISH : S_RD_DATA;
         end
         S_RD_DATA: begin
            cmd.op   = OP_LATCH_DATA;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.op = OP_FINISH;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      cmd.tail = tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/ttb_dp.sv
// Datapath: allocator, pointer decode, table store access and result register.
`timescale 1ns / 1ps
`default_nettype none
module ttb_dp import ttb_pkg::*; #(
   parameter int NUM_SLOTS  = 16,
   parameter int SLOT_SHIFT = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire ctl_cmd_type cmd,
   output dp_stat_type      stat
);
   localparam int SW    = $clog2(NUM_SLOTS);
   localparam int DEPTH = NUM_SLOTS * 512;
   localparam int AW    = $clog2(DEPTH);

   logic [31:0]   base_ff, base_in;
   logic [4:0]    limit_ff, limit_in;
   logic [4:0]    su_ff, su_in;
   logic [31:0]   cur_ff, cur_in;
   logic          open_ff, open_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic [63:0]   attr_ff, attr_in;
   logic          last_ff, last_in;
   logic [3:0]    rslot_ff, rslot_in;
   logic [8:0]    ridx_ff, ridx_in;
   logic [31:0]   pa_ff, pa_in;
   logic [1:0]    idx_ff, idx_in;
   logic [1:0]    idx_end_ff, idx_end_in;
   logic [9:0]    jdx_ff, jdx_in;
   logic [8:0]    jdx_end_ff, jdx_end_in;
   logic [9:0]    kdx_ff, kdx_in;
   logic [8:0]    kdx_end_ff, kdx_end_in;
   logic [1:0]    lk_ff, lk_in;
   logic [8:0]    kk_ff, kk_in;
   logic [63:0]   e_ff, e_in;
   logic [63:0]   blk_ff, blk_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   rt_ff, rt_in;
   logic [SW-1:0] sroot_ff, sroot_in;
   logic [SW-1:0] sl2_ff, sl2_in;
   logic [SW-1:0] sl3_ff, sl3_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   rout_ff, rout_in;
   logic [63:0]   data_ff, data_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata, mem_rdata;

   logic [31:0]   dec_p, dec_s, alloc_lim, alloc_addr, area_end, rslot_w;
   logic          dec_ok, alloc_ok, rd_bad, fault, fin;
   logic [SW-1:0] dec_slot;
   logic [4:0]    su_inc;
   logic [9:0]    kend;

   ttb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      case (cmd.op)
         OP_DEC_CUR: dec_p = cur_ff;
         OP_DEC_L2:  dec_p = mem_rdata[31:0];
         OP_DEC_L3:  dec_p = e_ff[31:0];
         default:    dec_p = a_ff;
      endcase
   end

   assign dec_s      = ((dec_p & PTR_MASK) - base_ff) >> SLOT_SHIFT;
   assign dec_ok     = dec_s < 32'(NUM_SLOTS);
   assign dec_slot   = dec_s[SW-1:0];
   assign alloc_lim  = (32'(limit_ff) < 32'(NUM_SLOTS)) ? 32'(limit_ff) : 32'(NUM_SLOTS);
   assign alloc_ok   = 32'(su_ff) < alloc_lim;
   assign alloc_addr = base_ff + (32'(su_ff) << SLOT_SHIFT);
   assign su_inc     = (su_ff == SLOTS_SAT) ? su_ff : su_ff + 5'd1;
   assign rslot_w    = 32'(rslot_ff);
   assign rd_bad     = rslot_w >= 32'(NUM_SLOTS);
   assign area_end   = req_data.phys_end - req_data.phys_start + req_data.virt_start;
   assign fin        = !(idx_ff < idx_end_ff);
   assign kend       = cmd.tail ? {1'b0, kdx_end_ff} : ENTRY_COUNT;

   always_comb begin
      base_in = base_ff; limit_in = limit_ff; su_in = su_ff; cur_in = cur_ff;
      open_in = open_ff; clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd_in = cmd_ff; attr_in = attr_ff; last_in = last_ff; rslot_in = rslot_ff;
      ridx_in = ridx_ff; pa_in = pa_ff; idx_in = idx_ff; idx_end_in = idx_end_ff;
      jdx_in = jdx_ff; jdx_end_in = jdx_end_ff; kdx_in = kdx_ff; kdx_end_in = kdx_end_ff;
      lk_in = lk_ff; kk_in = kk_ff; e_in = e_ff; blk_in = blk_ff; a_in = a_ff;
      rt_in = rt_ff; sroot_in = sroot_ff; sl2_in = sl2_ff; sl3_in = sl3_ff;
      st_in = st_ff; rout_in = rout_ff; data_in = data_ff; rsp_in = rsp_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
      mem_re = 1'b0; mem_raddr = '0;
      fault = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_TABLE_BASE:  base_in = csr_wdata;
            CSR_TABLE_LIMIT: limit_in = csr_wdata[4:0];
            default:         base_in = base_ff;
         endcase
      end

      if (cmd.load) begin
         cmd_in     = req_data.command;
         attr_in    = req_data.attr;
         last_in    = req_data.last_area;
         rslot_in   = req_data.read_slot;
         ridx_in    = req_data.read_index;
         pa_in      = req_data.phys_start;
         idx_in     = req_data.virt_start[31:30];
         idx_end_in = area_end[31:30];
         jdx_in     = {1'b0, req_data.virt_start[29:21]};
         jdx_end_in = area_end[29:21];
         kdx_in     = {1'b0, req_data.virt_start[20:12]};
         kdx_end_in = area_end[20:12];
         lk_in      = '0;
         st_in      = ST_OK;
         rout_in    = '0;
         data_in    = '0;
      end

      case (cmd.op)
         OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
         end
         OP_ALIGN: begin
            open_in = 1'b0;
            if (su_ff[0]) su_in = su_inc;
         end
         OP_ALLOC: begin
            fault = !alloc_ok;
            if (alloc_ok) begin
               a_in  = alloc_addr;
               su_in = su_inc;
            end else begin
               st_in = ST_NOSLOT;
            end
         end
         OP_BUMP: su_in = su_inc;
         OP_DEC_ROOT: begin
            fault    = !dec_ok;
            rt_in    = a_ff;
            sroot_in = dec_slot;
            if (!dec_ok) st_in = ST_BADPTR;
         end
         OP_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = {sroot_ff, 7'b0, lk_ff};
            mem_wdata = {32'b0, a_ff | DESC_TABLE};
            lk_in     = lk_ff + 2'd1;
         end
         OP_SET_ROOT: begin
            cur_in  = rt_ff;
            open_in = 1'b1;
            rout_in = rt_ff;
         end
         OP_NOROOT: st_in = ST_NOROOT;
         OP_DEC_CUR: begin
            fault    = !dec_ok;
            sroot_in = dec_slot;
            if (!dec_ok) st_in = ST_BADPTR;
         end
         OP_RD_ROOT: begin
            mem_re    = 1'b1;
            mem_raddr = {sroot_ff, 7'b0, idx_ff};
         end
         OP_DEC_L2: begin
            fault  = !dec_ok;
            sl2_in = dec_slot;
            if (!dec_ok) st_in = ST_BADPTR;
         end
         OP_BLOCK: begin
            mem_we    = 1'b1;
            mem_waddr = {sl2_ff, jdx_ff[8:0]};
            mem_wdata = attr_ff | {32'b0, pa_ff} | DESC_BLOCK;
            pa_in     = pa_ff + BLOCK_SIZE;
            jdx_in    = jdx_ff + 10'd1;
         end
         OP_NEXT_IDX: begin
            jdx_in = '0;
            idx_in = idx_ff + 2'd1;
         end
         OP_RD_L2E: begin
            mem_re    = 1'b1;
            mem_raddr = {sl2_ff, jdx_ff[8:0]};
         end
         OP_LATCH_E: begin
            e_in   = mem_rdata;
            blk_in = mem_rdata | SPLIT_MARK;
         end
         OP_SET_E: begin
            mem_we    = 1'b1;
            mem_waddr = {sl2_ff, jdx_ff[8:0]};
            mem_wdata = {32'b0, a_ff | DESC_TABLE};
            e_in      = {32'b0, a_ff | DESC_TABLE};
         end
         OP_DEC_SPLIT: begin
            fault  = !dec_ok;
            sl3_in = dec_slot;
            kk_in  = '0;
            if (!dec_ok) st_in = ST_BADPTR;
         end
         OP_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = {sl3_ff, kk_ff};
            mem_wdata = blk_ff;
            blk_in    = blk_ff + {32'b0, PAGE_SIZE};
            kk_in     = kk_ff + 9'd1;
         end
         OP_DEC_L3: begin
            fault  = !dec_ok;
            sl3_in = dec_slot;
            if (!dec_ok) st_in = ST_BADPTR;
         end
         OP_PAGE: begin
            mem_we    = 1'b1;
            mem_waddr = {sl3_ff, kdx_ff[8:0]};
            mem_wdata = attr_ff | {32'b0, pa_ff} | DESC_PAGE;
            pa_in     = pa_ff + PAGE_SIZE;
            kdx_in    = kdx_ff + 10'd1;
         end
         OP_PG_RET: begin
            jdx_in = jdx_ff + 10'd1;
            kdx_in = '0;
         end
         OP_AREA_END: begin
            if (st_ff != ST_OK || last_ff) open_in = 1'b0;
         end
         OP_RD_DATA: begin
            fault = rd_bad;
            if (rd_bad) begin
               st_in = ST_BADPTR;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {rslot_w[SW-1:0], ridx_ff};
            end
         end
         OP_LATCH_DATA: data_in = mem_rdata;
         OP_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = st_ff;
               rsp_in.root_address = rout_ff;
               rsp_in.read_data    = data_ff;
            end
         end
         default: fault = 1'b0;
      endcase
   end

   always_comb begin
      stat.fault      = fault;
      stat.command    = cmd_ff;
      stat.root_open  = open_ff;
      stat.e_zero     = (e_ff == 64'b0);
      stat.e_block    = (e_ff[1:0] == DESC_BLOCK[1:0]);
      stat.page_more  = kdx_ff < kend;
      stat.block_more = fin ? (jdx_ff < {1'b0, jdx_end_ff}) : (jdx_ff < ENTRY_COUNT);
      stat.fin        = fin;
      stat.pg_need    = fin ? ((kdx_ff != 10'b0) && (jdx_ff < {1'b0, jdx_end_ff}))
                            : (kdx_ff != 10'b0);
      stat.tail_need  = kdx_ff < {1'b0, kdx_end_ff};
      stat.split_last = (kk_ff == ENTRY_LAST);
      stat.link_last  = (lk_ff == LINK_LAST);
      stat.clear_last = (clr_ff == AW'(DEPTH - 1));
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         limit_ff     <= 5'd16;
         su_ff        <= '0;
         cur_ff       <= '0;
         open_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         su_ff        <= su_in;
         cur_ff       <= cur_in;
         open_ff      <= open_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; attr_ff <= attr_in; last_ff <= last_in; rslot_ff <= rslot_in;
      ridx_ff <= ridx_in; pa_ff <= pa_in; idx_ff <= idx_in; idx_end_ff <= idx_end_in;
      jdx_ff <= jdx_in; jdx_end_ff <= jdx_end_in; kdx_ff <= kdx_in;
      kdx_end_ff <= kdx_end_in; lk_ff <= lk_in; kk_ff <= kk_in; e_ff <= e_in;
      blk_ff <= blk_in; a_ff <= a_in; rt_ff <= rt_in; sroot_ff <= sroot_in;
      sl2_ff <= sl2_in; sl3_ff <= sl3_in; st_ff <= st_in; rout_ff <= rout_in;
      data_ff <= data_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

### rtl/core/ttb_checker.sv
// Port-level checks of the translation table builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ttb_checker import ttb_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.root_address == 32'b0 && rsp_data.read_data == 64'b0)
      else $error("failed request returned data");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 64'b0 |-> rsp_data.root_address == 32'b0)
      else $error("read and setup results mixed");
endmodule

bind translation_table_builder_core ttb_checker u_chk (.*);
`default_nettype wire
